// ===== hdl/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int unsigned MaxRes = 4;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_CTRL_WS  = 3'd1,
		ERR_BAD_ESC  = 3'd2,
		ERR_BAD_HEX  = 3'd3,
		ERR_BAD_PAIR = 3'd4,
		ERR_LONE_LOW = 3'd5
	} err_t;

	typedef enum logic [5:0] {
		MODE_PLAIN   = 6'b000001,
		MODE_ESC     = 6'b000010,
		MODE_HEX1    = 6'b000100,
		MODE_NEED_BS = 6'b001000,
		MODE_NEED_U  = 6'b010000,
		MODE_HEX2    = 6'b100000
	} mode_t;

	// one decoded input word: up to four result words
	typedef struct packed {
		logic [2:0]                n;
		logic [MaxRes-1:0][7:0]    bytes;
		logic                      byte_ok;
		logic                      str_end;
		err_t                      err;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/jsu_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one raw string byte per word.
// ----------------------------------------------------------------------------
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       restart;

	modport source (output valid, output in_byte, output restart, input ready);
	modport sink   (input valid, input in_byte, input restart, output ready);
endinterface
`default_nettype wire

// ===== hdl/jsu_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte or status per word.
// ----------------------------------------------------------------------------
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       string_end;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, output out_byte, output out_valid, output string_end,
		output error_code, output last, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input string_end,
		input error_code, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/jsu_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Escape / \uXXXX decoder state and next-result logic for one byte.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic [7:0]  in_byte,
	input  wire logic        restart,
	output jsu_pkg::res_t    res
);

	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChSlash  = 8'h2F;

	jsu_pkg::mode_t mode_q, mode_eff, mode_n;
	logic [15:0]    acc_q, acc_n, acc_shift;
	logic [1:0]     cnt_q, cnt_n, cnt_eff;
	logic [9:0]     hs_q, hs_n;
	logic           hex_ok;
	logic [3:0]     hex_val;

	function automatic jsu_pkg::res_t utf8(input logic [20:0] t);
		jsu_pkg::res_t r;
		r = '0;
		r.byte_ok = 1'b1;
		r.err     = jsu_pkg::ERR_NONE;
		if (t <= 21'h7F) begin
			r.n        = 3'd1;
			r.bytes[0] = t[7:0];
		end else if (t <= 21'h7FF) begin
			r.n        = 3'd2;
			r.bytes[0] = {3'b110, t[10:6]};
			r.bytes[1] = {2'b10, t[5:0]};
		end else if (t <= 21'hFFFF) begin
			r.n        = 3'd3;
			r.bytes[0] = {4'b1110, t[15:12]};
			r.bytes[1] = {2'b10, t[11:6]};
			r.bytes[2] = {2'b10, t[5:0]};
		end else begin
			r.n        = 3'd4;
			r.bytes[0] = {5'b11110, t[20:18]};
			r.bytes[1] = {2'b10, t[17:12]};
			r.bytes[2] = {2'b10, t[11:6]};
			r.bytes[3] = {2'b10, t[5:0]};
		end
		return r;
	endfunction

	function automatic jsu_pkg::res_t fail(input jsu_pkg::err_t e);
		jsu_pkg::res_t r;
		r     = '0;
		r.n   = 3'd1;
		r.err = e;
		return r;
	endfunction

	function automatic jsu_pkg::res_t one_byte(input logic [7:0] b);
		jsu_pkg::res_t r;
		r          = '0;
		r.n        = 3'd1;
		r.byte_ok  = 1'b1;
		r.bytes[0] = b;
		r.err      = jsu_pkg::ERR_NONE;
		return r;
	endfunction

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign mode_eff  = restart ? jsu_pkg::MODE_PLAIN : mode_q;
	assign cnt_eff   = restart ? 2'd0 : cnt_q;
	assign acc_shift = {(restart ? 12'd0 : acc_q[11:0]), hex_val};

	always_comb begin
		mode_n = jsu_pkg::MODE_PLAIN;
		acc_n  = restart ? 16'd0 : acc_q;
		cnt_n  = cnt_eff;
		hs_n   = restart ? 10'd0 : hs_q;
		res    = '0;
		unique case (mode_eff)
			jsu_pkg::MODE_ESC: begin
				unique case (in_byte)
					8'h62:    res = one_byte(8'h08);
					8'h66:    res = one_byte(8'h0C);
					8'h6E:    res = one_byte(8'h0A);
					8'h72:    res = one_byte(8'h0D);
					8'h74:    res = one_byte(8'h09);
					ChQuote:  res = one_byte(ChQuote);
					ChSlash:  res = one_byte(ChSlash);
					ChBslash: res = one_byte(ChBslash);
					8'h75: begin
						mode_n = jsu_pkg::MODE_HEX1;
						acc_n  = 16'd0;
						cnt_n  = 2'd0;
					end
					default: begin
						res   = fail(jsu_pkg::ERR_BAD_ESC);
						cnt_n = 2'd0;
					end
				endcase
			end
			jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
				if (!hex_ok) begin
					res   = fail(jsu_pkg::ERR_BAD_HEX);
					cnt_n = 2'd0;
				end else begin
					acc_n = acc_shift;
					if (cnt_eff != 2'd3) begin
						cnt_n  = cnt_eff + 2'd1;
						mode_n = mode_eff;
					end else begin
						cnt_n = 2'd0;
						if (mode_eff == jsu_pkg::MODE_HEX1) begin
							if (acc_shift[15:10] == 6'b110110) begin
								hs_n   = acc_shift[9:0];
								mode_n = jsu_pkg::MODE_NEED_BS;
							end else if (acc_shift[15:10] == 6'b110111) begin
								res = fail(jsu_pkg::ERR_LONE_LOW);
							end else begin
								res = utf8({5'd0, acc_shift});
							end
						end else begin
							if (acc_shift[15:10] != 6'b110111) begin
								res = fail(jsu_pkg::ERR_BAD_PAIR);
							end else begin
								res = utf8(21'h10000 + {1'b0, hs_n, acc_shift[9:0]});
							end
						end
					end
				end
			end
			jsu_pkg::MODE_NEED_BS: begin
				if (in_byte != ChBslash) begin
					res   = fail(jsu_pkg::ERR_BAD_PAIR);
					cnt_n = 2'd0;
				end else begin
					mode_n = jsu_pkg::MODE_NEED_U;
				end
			end
			jsu_pkg::MODE_NEED_U: begin
				if (in_byte != 8'h75) begin
					res   = fail(jsu_pkg::ERR_BAD_PAIR);
					cnt_n = 2'd0;
				end else begin
					mode_n = jsu_pkg::MODE_HEX2;
					acc_n  = 16'd0;
					cnt_n  = 2'd0;
				end
			end
			default: begin
				if (in_byte >= 8'h09 && in_byte <= 8'h0D) begin
					res   = fail(jsu_pkg::ERR_CTRL_WS);
					cnt_n = 2'd0;
				end else if (in_byte == ChBslash) begin
					mode_n = jsu_pkg::MODE_ESC;
				end else if (in_byte == ChQuote) begin
					res         = '0;
					res.n       = 3'd1;
					res.str_end = 1'b1;
				end else begin
					res = one_byte(in_byte);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_PLAIN;
			acc_q  <= 16'd0;
			cnt_q  <= 2'd0;
			hs_q   <= 10'd0;
		end else if (adv) begin
			mode_q <= mode_n;
			acc_q  <= acc_n;
			cnt_q  <= cnt_n;
			hs_q   <= hs_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/json_string_unescape_utf8_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with UTF-16 surrogate pairs to UTF-8.
// ----------------------------------------------------------------------------
// channel  dir  payload                                          words
// din      in   in_byte[7:0], restart                            1 per byte
// dout     out  out_byte[7:0], out_valid, string_end,            0..4 per byte
//               error_code[2:0], last
//
// A byte is registered, decoded in the next cycle and its results loaded into
// a four-word result buffer that drains one word per cycle while dout is ready.
// One byte per cycle when each byte gives at most one word and dout is ready;
// a byte giving n words stalls the input until its last word is taken (the
// single output port sets this). Bytes that give no word never wait on the
// result buffer. arst_n clears the decoder to plain mode and empties both stages.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jsu_in_if.sink     din,
	jsu_out_if.source  dout
);

	logic                               vld_s1;
	logic [7:0]                         byte_s1;
	logic                               rst_s1;
	jsu_pkg::res_t                      res;
	logic                               adv;
	logic                               buf_free;
	logic                               out_fire;
	logic                               in_fire;
	logic                               last_out;

	logic                               busy_q;
	logic [1:0]                         ptr_q;
	logic [2:0]                         n_q;
	logic [jsu_pkg::MaxRes-1:0][7:0]    bytes_q;
	logic                               byte_ok_q;
	logic                               end_q;
	jsu_pkg::err_t                      err_q;

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_byte (byte_s1),
		.restart (rst_s1),
		.res     (res)
	);

	assign out_fire = dout.valid && dout.ready;
	assign last_out = ({1'b0, ptr_q} + 3'd1) == n_q;
	assign buf_free = !busy_q || (out_fire && last_out);
	assign adv      = vld_s1 && (buf_free || (res.n == 3'd0));
	assign din.ready = !vld_s1 || adv;
	assign in_fire  = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= din.in_byte;
			rst_s1  <= din.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ptr_q  <= 2'd0;
			n_q    <= 3'd0;
		end else if (adv && (res.n != 3'd0)) begin
			busy_q <= 1'b1;
			ptr_q  <= 2'd0;
			n_q    <= res.n;
		end else if (out_fire) begin
			if (last_out) begin
				busy_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (res.n != 3'd0)) begin
			bytes_q   <= res.bytes;
			byte_ok_q <= res.byte_ok;
			end_q     <= res.str_end;
			err_q     <= res.err;
		end
	end

	assign dout.valid      = busy_q;
	assign dout.out_byte   = bytes_q[ptr_q];
	assign dout.out_valid  = byte_ok_q;
	assign dout.string_end = end_q;
	assign dout.error_code = err_q;
	assign dout.last       = last_out;

endmodule
`default_nettype wire

// ===== verif/tb_json_string_unescape_utf8_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_core
// Drives raw JSON string body bytes into the unescaper in random bursts, with
// the output stalling on its own pattern and once for a long stretch. Every
// output word is checked against a behavioral decoder that tracks escape,
// \u hex and surrogate pair state. The stimulus mixes well-formed escapes and
// pairs with noise, broken sequences and random restarts.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_core;

	localparam int IdleLimit = 2000;
	localparam int LongHold  = 300;
	localparam int RawCount  = 324;

	typedef struct packed {
		logic [7:0] b;
		logic       rs;
	} raw_t;

	typedef struct packed {
		logic [7:0]    data;
		logic          data_ok;
		logic          str_end;
		jsu_pkg::err_t err;
		logic          last;
	} word_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  din_if();
	jsu_out_if dout_if();

	json_string_unescape_utf8_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #5 clk = ~clk;

	raw_t  raw_q[$];
	word_t decoded_q[$];

	// decoder state
	jsu_pkg::mode_t mode   = jsu_pkg::MODE_PLAIN;
	logic [15:0]    acc    = '0;
	logic [1:0]     cnt    = '0;
	logic [9:0]     hi_sur = '0;

	logic  in_fire  = 1'b0;
	logic  out_fire = 1'b0;
	word_t got_w;
	int    n_bad     = 0;
	int    n_bytes   = 0;
	int    idle_cyc  = 0;
	bit    rs_on     = 1'b0;

	int burst_left = 0;
	int gap_left   = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int rx_style   = 0;
	int phase_left = 0;
	int pat_cnt    = 0;

	task automatic push_word(input logic [7:0] d, input logic ok, input logic e,
		input jsu_pkg::err_t er, input logic l);
		word_t w;
		w.data    = d;
		w.data_ok = ok;
		w.str_end = e;
		w.err     = er;
		w.last    = l;
		decoded_q = {decoded_q, w};
	endtask

	task automatic unescape_byte(input logic [7:0] c, input logic rs);
		logic [7:0]    ob [4];
		logic [20:0]   cp;
		logic [7:0]    esc;
		int            n;
		int            h;
		logic          emit;
		logic          bad;
		logic          is_end;
		jsu_pkg::err_t fe;
		n      = 0;
		emit   = 1'b0;
		bad    = 1'b0;
		is_end = 1'b0;
		fe     = jsu_pkg::ERR_NONE;
		cp     = '0;
		esc    = '0;
		if (rs) begin
			mode   = jsu_pkg::MODE_PLAIN;
			acc    = '0;
			cnt    = '0;
			hi_sur = '0;
		end
		case (mode)
			jsu_pkg::MODE_ESC: begin
				mode = jsu_pkg::MODE_PLAIN;
				case (c)
					"b":  esc = 8'h08;
					"f":  esc = 8'h0C;
					"n":  esc = 8'h0A;
					"r":  esc = 8'h0D;
					"t":  esc = 8'h09;
					"\"": esc = "\"";
					"/":  esc = "/";
					"\\": esc = "\\";
					"u": begin
						mode = jsu_pkg::MODE_HEX1;
						acc  = '0;
						cnt  = '0;
					end
					default: begin
						bad = 1'b1;
						fe  = jsu_pkg::ERR_BAD_ESC;
					end
				endcase
				if (mode == jsu_pkg::MODE_PLAIN && !bad) begin
					ob[0] = esc;
					n     = 1;
				end
			end
			jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
				if (c >= "0" && c <= "9")      h = c - "0";
				else if (c >= "a" && c <= "f") h = c - "a" + 10;
				else if (c >= "A" && c <= "F") h = c - "A" + 10;
				else                           h = -1;
				if (h < 0) begin
					bad = 1'b1;
					fe  = jsu_pkg::ERR_BAD_HEX;
				end else begin
					acc = {acc[11:0], h[3:0]};
					if (cnt != 2'd3) begin
						cnt = cnt + 2'd1;
					end else begin
						cnt = '0;
						if (mode == jsu_pkg::MODE_HEX1) begin
							if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
								hi_sur = acc[9:0];
								mode   = jsu_pkg::MODE_NEED_BS;
							end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
								bad = 1'b1;
								fe  = jsu_pkg::ERR_LONE_LOW;
							end else begin
								mode = jsu_pkg::MODE_PLAIN;
								cp   = {5'b0, acc};
								emit = 1'b1;
							end
						end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
							bad = 1'b1;
							fe  = jsu_pkg::ERR_BAD_PAIR;
						end else begin
							mode = jsu_pkg::MODE_PLAIN;
							cp   = 21'h10000 + {1'b0, hi_sur, acc[9:0]};
							emit = 1'b1;
						end
					end
				end
			end
			jsu_pkg::MODE_NEED_BS: begin
				if (c != "\\") begin
					bad = 1'b1;
					fe  = jsu_pkg::ERR_BAD_PAIR;
				end else begin
					mode = jsu_pkg::MODE_NEED_U;
				end
			end
			jsu_pkg::MODE_NEED_U: begin
				if (c != "u") begin
					bad = 1'b1;
					fe  = jsu_pkg::ERR_BAD_PAIR;
				end else begin
					mode = jsu_pkg::MODE_HEX2;
					acc  = '0;
					cnt  = '0;
				end
			end
			default: begin
				mode = jsu_pkg::MODE_PLAIN;
				if (c >= 8'h09 && c <= 8'h0D) begin
					bad = 1'b1;
					fe  = jsu_pkg::ERR_CTRL_WS;
				end else if (c == "\\") begin
					mode = jsu_pkg::MODE_ESC;
				end else if (c == "\"") begin
					is_end = 1'b1;
				end else begin
					ob[0] = c;
					n     = 1;
				end
			end
		endcase
		if (emit) begin
			if (cp <= 21'h7F) begin
				ob[0] = cp[7:0];
				n     = 1;
			end else if (cp <= 21'h7FF) begin
				ob[0] = {3'b110, cp[10:6]};
				ob[1] = {2'b10, cp[5:0]};
				n     = 2;
			end else if (cp <= 21'hFFFF) begin
				ob[0] = {4'b1110, cp[15:12]};
				ob[1] = {2'b10, cp[11:6]};
				ob[2] = {2'b10, cp[5:0]};
				n     = 3;
			end else begin
				ob[0] = {5'b11110, cp[20:18]};
				ob[1] = {2'b10, cp[17:12]};
				ob[2] = {2'b10, cp[11:6]};
				ob[3] = {2'b10, cp[5:0]};
				n     = 4;
			end
		end
		if (bad) begin
			mode = jsu_pkg::MODE_PLAIN;
			cnt  = '0;
			push_word(8'h00, 1'b0, 1'b0, fe, 1'b1);
		end else if (is_end) begin
			push_word(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE, 1'b1);
		end
		for (int i = 0; i < n; i++)
			push_word(ob[i], 1'b1, 1'b0, jsu_pkg::ERR_NONE, i == n - 1);
	endtask

	// stimulus helpers
	task automatic put_in(input logic [7:0] b);
		raw_t r;
		r.b  = b;
		r.rs = rs_on && ($urandom_range(0, 39) == 0);
		raw_q = {raw_q, r};
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return "0" + v;
		return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
	endfunction

	task automatic put_u(input logic [15:0] v);
		put_in("\\");
		put_in("u");
		put_in(hex_char(v[15:12]));
		put_in(hex_char(v[11:8]));
		put_in(hex_char(v[7:4]));
		put_in(hex_char(v[3:0]));
	endtask

	function automatic logic [15:0] pick_val(input int lo_v, input int hi_v);
		case ($urandom_range(0, 3))
			0:       return lo_v[15:0];
			1:       return hi_v[15:0];
			default: return 16'($urandom_range(hi_v, lo_v));
		endcase
	endfunction

	// sender: bursts with random gaps, word held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			din_if.valid <= 1'b0;
		end else if (!(din_if.valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				din_if.valid <= 1'b0;
			end else if (raw_q.size() != 0) begin
				din_if.valid   <= 1'b1;
				din_if.in_byte <= raw_q[0].b;
				din_if.restart <= raw_q[0].rs;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern, plus one long hold to back up the input
	always @(negedge clk) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			dout_if.ready <= 1'b0;
		end else if (!hold_done && n_bytes >= 120) begin
			hold_done = 1'b1;
			hold_left = LongHold;
			dout_if.ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				rx_style   = $urandom_range(0, 2);
				phase_left = $urandom_range(16, 80);
			end else begin
				phase_left--;
			end
			pat_cnt++;
			case (rx_style)
				0:       dout_if.ready <= 1'b1;
				1:       dout_if.ready <= ($urandom_range(0, 3) != 0);
				default: dout_if.ready <= ((pat_cnt % 5) < 3);
			endcase
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire  = din_if.valid && din_if.ready;
			out_fire = dout_if.valid && dout_if.ready;
			if (in_fire) begin
				unescape_byte(din_if.in_byte, din_if.restart);
				void'(raw_q.pop_front());
				n_bytes++;
			end
			if (out_fire) begin
				if (decoded_q.size() == 0) begin
					if (n_bad < 10)
						$display("unexpected word: byte=%02h ok=%b end=%b err=%0d last=%b",
							dout_if.out_byte, dout_if.out_valid, dout_if.string_end,
							dout_if.error_code, dout_if.last);
					n_bad++;
				end else begin
					got_w = decoded_q.pop_front();
					if (dout_if.out_byte !== got_w.data || dout_if.out_valid !== got_w.data_ok ||
						dout_if.string_end !== got_w.str_end ||
						dout_if.error_code !== got_w.err || dout_if.last !== got_w.last) begin
						if (n_bad < 10) begin
							$display("mismatch: exp byte=%02h ok=%b end=%b err=%0d last=%b",
								got_w.data, got_w.data_ok, got_w.str_end, got_w.err,
								got_w.last);
							$display("          got byte=%02h ok=%b end=%b err=%0d last=%b",
								dout_if.out_byte, dout_if.out_valid,
								dout_if.string_end, dout_if.error_code, dout_if.last);
						end
						n_bad++;
					end
				end
			end
			if (in_fire || out_fire) begin
				idle_cyc = 0;
			end else begin
				idle_cyc++;
				if (idle_cyc >= IdleLimit) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [7:0]  b;
		logic [15:0] v;
		int          sel;
		raw_t        r;
		arst_n          = 1'b0;
		din_if.valid    = 1'b0;
		din_if.in_byte  = 8'h00;
		din_if.restart  = 1'b0;
		dout_if.ready   = 1'b0;

		// directed
		put_in(8'h00);
		r.b  = 8'hFF;
		r.rs = 1'b1;
		raw_q = {raw_q, r};
		put_in(8'h0D);
		put_in("\"");
		put_in("\\");
		put_in("q");
		put_in("\\");
		put_in("n");
		put_u(16'hD83D);
		put_u(16'hDE00);
		put_in("\\");
		put_in("u");
		put_in("0");
		put_in("G");

		// random
		rs_on = 1'b1;
		while (raw_q.size() < RawCount) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				do b = 8'($urandom_range(0, 255));
				while ((b >= 8'h09 && b <= 8'h0D) || b == "\\" || b == "\"");
				put_in(b);
			end else if (sel < 30) begin
				put_in(8'($urandom_range(0, 255)));
			end else if (sel < 42) begin
				case ($urandom_range(0, 7))
					0:       b = "b";
					1:       b = "f";
					2:       b = "n";
					3:       b = "r";
					4:       b = "t";
					5:       b = "\"";
					6:       b = "/";
					default: b = "\\";
				endcase
				put_in("\\");
				put_in(b);
			end else if (sel < 62) begin
				case ($urandom_range(0, 3))
					0:       v = pick_val('h0, 'h7F);
					1:       v = pick_val('h80, 'h7FF);
					2:       v = pick_val('h800, 'hD7FF);
					default: v = pick_val('hE000, 'hFFFF);
				endcase
				put_u(v);
			end else if (sel < 77) begin
				put_u(pick_val('hD800, 'hDBFF));
				put_u(pick_val('hDC00, 'hDFFF));
			end else if (sel < 80) begin
				put_u(pick_val('hDC00, 'hDFFF));
			end else if (sel < 84) begin
				put_u(pick_val('hD800, 'hDBFF));
				case ($urandom_range(0, 2))
					0: begin
						do b = 8'($urandom_range(0, 255));
						while (b == "\\");
						put_in(b);
					end
					1: begin
						put_in("\\");
						do b = 8'($urandom_range(0, 255));
						while (b == "u");
						put_in(b);
					end
					default: begin
						v = $urandom_range(0, 1) ? pick_val('h0, 'hDBFF) : pick_val('hE000, 'hFFFF);
						put_u(v);
					end
				endcase
			end else if (sel < 88) begin
				if ($urandom_range(0, 1))
					put_u(pick_val('hD800, 'hDBFF));
				put_in("\\");
				put_in("u");
				repeat ($urandom_range(0, 3))
					put_in(hex_char(4'($urandom_range(0, 15))));
				do b = 8'($urandom_range(0, 255));
				while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
				put_in(b);
			end else if (sel < 91) begin
				do b = 8'($urandom_range(0, 255));
				while (b == "b" || b == "f" || b == "n" || b == "r" || b == "t" || b == "\"" ||
					b == "/" || b == "\\" || b == "u");
				put_in("\\");
				put_in(b);
			end else if (sel < 95) begin
				put_in(8'($urandom_range(9, 13)));
			end else begin
				put_in("\"");
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (raw_q.size() != 0) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (n_bad == 0 && decoded_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
